### hdl/cba_pkg.sv
// cba_pkg: request and status codes, controller command and datapath status
// structs for the cluster bitmap allocator
// no dependencies
package cba_pkg;

	localparam int FW = 17;
	localparam int KW = 18;

	localparam logic [2:0] REQ_ALLOC   = 3'd0;
	localparam logic [2:0] REQ_FREE    = 3'd1;
	localparam logic [2:0] REQ_FIND    = 3'd2;
	localparam logic [2:0] REQ_LOAD    = 3'd3;
	localparam logic [2:0] REQ_RECOUNT = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_ALREADY  = 2'd2;

	localparam logic [KW-1:0] CLUSTER_BASE = 18'd2;

	typedef enum logic [1:0] {
		CS_ZERO,
		CS_K,
		CS_C,
		CS_S
	} csel_t;

	typedef struct packed {
		logic       latch;
		logic       rd;
		logic       set_bit;
		logic       clr_bit;
		logic       ld_word;
		logic       k_wrap;
		logic       k_inc;
		logic       k_add32;
		logic       t_clr;
		logic       t_inc;
		logic       i_inc;
		logic       free_dec;
		logic       free_inc;
		logic       free_ld;
		logic       s_ld;
		logic       run_inc;
		logic       acc_add;
		logic       emit;
		logic [1:0] st;
		csel_t      csel;
		logic       run_en;
		logic       last;
	} cba_cmd_t;

	typedef struct packed {
		logic       bit_used;
		logic       k_ge_c;
		logic       t_end;
		logic       free_zero;
		logic       i_last;
		logic       i_done;
		logic       slot_free;
		logic [2:0] req_type;
	} cba_sts_t;

endpackage

### hdl/cba_req_if.sv
// cba_req_if: request channel, valid/ready with request payload
// no dependencies
interface cba_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [16:0] cluster;
	logic [6:0]  count;
	logic [10:0] word_index;
	logic [31:0] word_data;

	modport source (output valid, req_type, cluster, count, word_index, word_data,
		input ready);
	modport sink (input valid, req_type, cluster, count, word_index, word_data,
		output ready);
endinterface

### hdl/cba_res_if.sv
// cba_res_if: result channel, valid/ready with result payload
// no dependencies
interface cba_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [16:0] cluster_out;
	logic [16:0] run_length;
	logic [16:0] free_count;
	logic        last;

	modport source (output valid, status, cluster_out, run_length, free_count, last,
		input ready);
	modport sink (input valid, status, cluster_out, run_length, free_count, last,
		output ready);
endinterface

### hdl/cba_cfg_if.sv
// cba_cfg_if: configuration write channel for clusters_in_use
// no dependencies
interface cba_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hdl/cba_datapath.sv
// cba_datapath: bitmap memory, cursor, counters, free count and result register
// depends on cba_pkg
module cba_datapath
	import cba_pkg::*;
#(
	parameter int MAX_CLUSTERS = 65536,
	parameter int MAX_BURST = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cba_cmd_t       cmd,
	output cba_sts_t       sts,
	input  logic [2:0]     req_type,
	input  logic [FW-1:0]  cluster,
	input  logic [6:0]     count,
	input  logic [10:0]    word_index,
	input  logic [31:0]    word_data,
	input  logic           cfg_we,
	input  logic [FW-1:0]  cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic [FW-1:0]  out_cl,
	output logic [FW-1:0]  out_run,
	output logic [FW-1:0]  out_free,
	output logic           out_last
);

	localparam int WORDS = (MAX_CLUSTERS + 31) / 32;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [31:0]   mem [WORDS];
	logic [31:0]   rdata_q;
	logic [FW-1:0] cfg_q;
	logic [2:0]    type_q;
	logic [6:0]    cnt_q;
	logic [6:0]    i_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] t_q;
	logic [KW-1:0] s_q;
	logic [FW-1:0] run_q;
	logic [FW-1:0] free_q;
	logic [10:0]   widx_q;
	logic [31:0]   wdat_q;
	logic          out_valid_q;
	logic [1:0]    st_q;
	logic [FW-1:0] cl_out_q;
	logic [FW-1:0] run_out_q;
	logic [FW-1:0] free_out_q;
	logic          last_q;

	logic [KW-1:0] c;
	logic [KW-1:0] cl_m2;
	logic [KW-1:0] k_p1;
	logic [KW-1:0] rem;
	logic [31:0]   mask;
	logic [31:0]   wdata;
	logic [AW-1:0] addr;
	logic [6:0]    cnt_alloc;
	logic [6:0]    cnt_free;
	logic [FW-1:0] cl_sel;

	always_comb begin
		if (cfg_q == '0) begin
			c = 18'd1;
		end else if (32'(cfg_q) > MAX_CLUSTERS) begin
			c = KW'(MAX_CLUSTERS);
		end else begin
			c = {1'b0, cfg_q};
		end
	end

	assign cl_m2 = {1'b0, cluster} - CLUSTER_BASE;
	assign k_p1 = k_q + 18'd1;
	assign rem = c - k_q;
	assign mask = (rem >= 18'd32) ? '1 : ((32'd1 << rem[4:0]) - 32'd1);
	assign addr = AW'(k_q >> 5);

	always_comb begin
		if (count == '0) begin
			cnt_alloc = 7'd1;
		end else if (32'(count) > MAX_BURST) begin
			cnt_alloc = 7'(MAX_BURST);
		end else begin
			cnt_alloc = count;
		end
		cnt_free = (32'(count) > MAX_BURST) ? 7'(MAX_BURST) : count;
	end

	always_comb begin
		wdata = rdata_q;
		wdata[k_q[4:0]] = cmd.set_bit;
	end

	// bitmap store, no reset
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
		if (cmd.set_bit || cmd.clr_bit) begin
			mem[addr] <= wdata;
		end else if (cmd.ld_word && (32'(widx_q) < WORDS)) begin
			mem[AW'(widx_q)] <= wdat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 17'd65536;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			free_q <= '0;
		end else begin
			if (cmd.latch) begin
				unique case (req_type)
					REQ_ALLOC: k_q <= (cl_m2 < c) ? cl_m2 : '0;
					REQ_RECOUNT: k_q <= '0;
					default: k_q <= cl_m2;
				endcase
			end else if (cmd.k_wrap) begin
				k_q <= (k_p1 >= c) ? '0 : k_p1;
			end else if (cmd.k_inc) begin
				k_q <= k_p1;
			end else if (cmd.k_add32) begin
				k_q <= k_q + 18'd32;
			end
			if (cmd.free_dec) begin
				free_q <= free_q - 17'd1;
			end else if (cmd.free_inc) begin
				if (KW'(free_q) < c) begin
					free_q <= free_q + 17'd1;
				end
			end else if (cmd.free_ld) begin
				free_q <= run_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			type_q <= req_type;
			cnt_q <= (req_type == REQ_ALLOC) ? cnt_alloc : cnt_free;
			i_q <= '0;
			run_q <= '0;
			widx_q <= word_index;
			wdat_q <= word_data;
		end else begin
			if (cmd.i_inc) begin
				i_q <= i_q + 7'd1;
			end
			if (cmd.s_ld) begin
				s_q <= k_q;
				run_q <= '0;
			end else if (cmd.run_inc) begin
				run_q <= run_q + 17'd1;
			end else if (cmd.acc_add) begin
				run_q <= run_q + 17'($countones(~rdata_q & mask));
			end
		end
		if (cmd.t_clr) begin
			t_q <= '0;
		end else if (cmd.t_inc) begin
			t_q <= t_q + 18'd1;
		end
	end

	always_comb begin
		case (cmd.csel)
			CS_K: cl_sel = FW'(k_q + CLUSTER_BASE);
			CS_C: cl_sel = FW'(c);
			CS_S: cl_sel = FW'(s_q + CLUSTER_BASE);
			default: cl_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			st_q <= cmd.st;
			cl_out_q <= cl_sel;
			run_out_q <= cmd.run_en ? run_q : '0;
			free_out_q <= free_q;
			last_q <= cmd.last;
		end
	end

	assign sts.bit_used = rdata_q[k_q[4:0]];
	assign sts.k_ge_c = (k_q >= c);
	assign sts.t_end = ((t_q + 18'd1) == c);
	assign sts.free_zero = (free_q == '0);
	assign sts.i_last = ((i_q + 7'd1) == cnt_q);
	assign sts.i_done = (i_q == cnt_q);
	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.req_type = type_q;

	assign out_valid = out_valid_q;
	assign out_status = st_q;
	assign out_cl = cl_out_q;
	assign out_run = run_out_q;
	assign out_free = free_out_q;
	assign out_last = last_q;

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting item");
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("loaded result not shown");
	a_nospace_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (cmd.st != ST_OK)) |-> cmd.last)
		else $error("failing result not marked last");
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_bit || cmd.clr_bit) |-> !cmd.rd)
		else $error("bitmap read and write in one cycle");

endmodule

### hdl/cba_controller.sv
// cba_controller: request sequencer for allocate, free, find, load and recount
// depends on cba_pkg
module cba_controller
	import cba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [2:0] in_type,
	input  cba_sts_t sts,
	output cba_cmd_t cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_A_CHK  = 5'd1;
	localparam logic [4:0] S_A_RD   = 5'd2;
	localparam logic [4:0] S_A_TST  = 5'd3;
	localparam logic [4:0] S_AOK    = 5'd4;
	localparam logic [4:0] S_NOSP   = 5'd5;
	localparam logic [4:0] S_F_CHK  = 5'd6;
	localparam logic [4:0] S_F_RD   = 5'd7;
	localparam logic [4:0] S_F_TST  = 5'd8;
	localparam logic [4:0] S_AFREE  = 5'd9;
	localparam logic [4:0] S_OK0    = 5'd10;
	localparam logic [4:0] S_D_CHK  = 5'd11;
	localparam logic [4:0] S_D_RD   = 5'd12;
	localparam logic [4:0] S_D_TST  = 5'd13;
	localparam logic [4:0] S_D_RCHK = 5'd14;
	localparam logic [4:0] S_D_RRD  = 5'd15;
	localparam logic [4:0] S_D_RTST = 5'd16;
	localparam logic [4:0] S_FNONE  = 5'd17;
	localparam logic [4:0] S_FRUN   = 5'd18;
	localparam logic [4:0] S_LOAD   = 5'd19;
	localparam logic [4:0] S_R_CHK  = 5'd20;
	localparam logic [4:0] S_R_RD   = 5'd21;
	localparam logic [4:0] S_R_ACC  = 5'd22;
	localparam logic [4:0] S_R_END  = 5'd23;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.csel = CS_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (in_type)
						REQ_ALLOC: state_d = S_A_CHK;
						REQ_FREE: state_d = S_F_CHK;
						REQ_FIND: state_d = S_D_CHK;
						REQ_LOAD: state_d = S_LOAD;
						REQ_RECOUNT: state_d = S_R_CHK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_A_CHK: begin
				cmd.t_clr = 1'b1;
				state_d = sts.free_zero ? S_NOSP : S_A_RD;
			end
			S_A_RD: begin
				cmd.rd = 1'b1;
				state_d = S_A_TST;
			end
			S_A_TST: begin
				if (!sts.bit_used) begin
					cmd.set_bit = 1'b1;
					cmd.free_dec = 1'b1;
					state_d = S_AOK;
				end else if (sts.t_end) begin
					state_d = S_NOSP;
				end else begin
					cmd.k_wrap = 1'b1;
					cmd.t_inc = 1'b1;
					state_d = S_A_RD;
				end
			end
			S_AOK: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_OK;
					cmd.csel = CS_K;
					cmd.last = sts.i_last;
					cmd.i_inc = 1'b1;
					state_d = sts.i_last ? S_IDLE : S_A_CHK;
				end
			end
			S_NOSP: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_NO_SPACE;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_F_CHK: begin
				if (sts.i_done) begin
					state_d = S_OK0;
				end else if (sts.k_ge_c) begin
					state_d = S_AFREE;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_RD: begin
				cmd.rd = 1'b1;
				state_d = S_F_TST;
			end
			S_F_TST: begin
				if (!sts.bit_used) begin
					state_d = S_AFREE;
				end else begin
					cmd.clr_bit = 1'b1;
					cmd.free_inc = 1'b1;
					cmd.k_inc = 1'b1;
					cmd.i_inc = 1'b1;
					state_d = S_F_CHK;
				end
			end
			S_AFREE: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_ALREADY;
					cmd.csel = CS_K;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_OK0: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_OK;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_D_CHK: begin
				state_d = sts.k_ge_c ? S_FNONE : S_D_RD;
			end
			S_D_RD: begin
				cmd.rd = 1'b1;
				state_d = S_D_TST;
			end
			S_D_TST: begin
				if (sts.bit_used) begin
					cmd.s_ld = 1'b1;
					state_d = S_D_RCHK;
				end else begin
					cmd.k_inc = 1'b1;
					state_d = S_D_CHK;
				end
			end
			S_D_RCHK: begin
				state_d = sts.k_ge_c ? S_FRUN : S_D_RRD;
			end
			S_D_RRD: begin
				cmd.rd = 1'b1;
				state_d = S_D_RTST;
			end
			S_D_RTST: begin
				if (sts.bit_used) begin
					cmd.run_inc = 1'b1;
					cmd.k_inc = 1'b1;
					state_d = S_D_RCHK;
				end else begin
					state_d = S_FRUN;
				end
			end
			S_FNONE: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_OK;
					cmd.csel = CS_C;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FRUN: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.st = ST_OK;
					cmd.csel = CS_S;
					cmd.run_en = 1'b1;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.ld_word = 1'b1;
				state_d = S_OK0;
			end
			S_R_CHK: begin
				state_d = sts.k_ge_c ? S_R_END : S_R_RD;
			end
			S_R_RD: begin
				cmd.rd = 1'b1;
				state_d = S_R_ACC;
			end
			S_R_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.k_add32 = 1'b1;
				state_d = S_R_CHK;
			end
			S_R_END: begin
				cmd.free_ld = 1'b1;
				state_d = S_OK0;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_alloc_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_type == REQ_ALLOC)) |=> (state_q == S_A_CHK))
		else $error("allocate not started");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_type == REQ_LOAD)) |=> !in_ready)
		else $error("load accepted without work");
	a_free_ok_type: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F_TST) |-> (sts.req_type == REQ_FREE))
		else $error("free step on other request");

endmodule

### hdl/cluster_bitmap_allocator.sv
// cluster_bitmap_allocator: next-fit bitmap allocator top level, one request at a time
// load: word written, then result loaded; free and find: check, read, test per bit
// allocate: check, read, test per bit, emit per cluster; recount: read, add per word
// a result held by the sink stalls the sequencer in its emitting state
// reset: cursor and free count cleared, bitmap memory undefined until loaded
// depends on cba_pkg, cba_req_if, cba_res_if, cba_cfg_if, cba_controller, cba_datapath
module cluster_bitmap_allocator
	import cba_pkg::*;
#(
	parameter int MAX_CLUSTERS = 65536,
	parameter int MAX_BURST = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	cba_req_if.sink  req,
	cba_res_if.source res,
	cba_cfg_if.sink  cfg
);

	cba_cmd_t cmd;
	cba_sts_t sts;

	assign cfg.ready = 1'b1;

	cba_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_type  (req.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	cba_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_BURST    (MAX_BURST)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.cluster     (req.cluster),
		.count       (req.count),
		.word_index  (req.word_index),
		.word_data   (req.word_data),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.out_status  (res.status),
		.out_cl      (res.cluster_out),
		.out_run     (res.run_length),
		.out_free    (res.free_count),
		.out_last    (res.last)
	);

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the cluster bitmap allocator, with its own
// prediction of bitmap, search cursor and free count and random idling on both sides
// depends on cba_pkg, cba_req_if, cba_res_if, cba_cfg_if and cluster_bitmap_allocator
module testbench;
	import cba_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 60;
	localparam int NWORDS = 2048;
	localparam int LOADED = 64;

	typedef struct packed {
		logic [1:0]  status;
		logic [16:0] cluster_out;
		logic [16:0] run_length;
		logic [16:0] free_count;
		logic        last;
	} alloc_res_t;

	logic clk;
	logic arst_n;

	cba_req_if req_ch();
	cba_res_if res_ch();
	cba_cfg_if cfg_ch();

	cluster_bitmap_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	logic [31:0] used_map [NWORDS];
	int unsigned cursor;
	int unsigned free_left;
	logic [16:0] vol_reg;

	alloc_res_t expected_q [$];
	int errors;
	int items_sent;
	int results_seen;
	int phases_run;
	int cycles;
	bit quiet;
	bit took;
	int res_stall;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result checking
	always @(posedge clk) begin
		alloc_res_t got;
		alloc_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.status, res_ch.cluster_out, res_ch.run_length,
				res_ch.free_count, res_ch.last};
			took = 1'b1;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %p", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
				end
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (took) begin
			took = 1'b0;
			res_stall = quiet ? 0 : $urandom_range(0, 3);
		end
		if (res_stall > 0) begin
			res_ch.ready <= 1'b0;
			res_stall--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	function automatic int unsigned volume();
		int unsigned c;
		c = vol_reg;
		if (c < 1) c = 1;
		if (c > 65536) c = 65536;
		return c;
	endfunction

	function automatic bit is_used(int unsigned k);
		return used_map[(k >> 5) % NWORDS][k & 31];
	endfunction

	function automatic void push_result(logic [1:0] st, int unsigned cl, int unsigned run,
		bit fin);
		expected_q.push_back('{st, cl[16:0], run[16:0], free_left[16:0], fin});
	endfunction

	function automatic void predict_request(logic [2:0] rt, logic [16:0] cl,
		logic [6:0] cnt_in, logic [10:0] wi, logic [31:0] wd);
		int unsigned c, cnt, i, t, s, k, run, idx, n;
		bit found;
		c = volume();
		cnt = cnt_in;
		case (rt)
			REQ_ALLOC: begin
				if (cnt < 1) cnt = 1;
				if (cnt > 64) cnt = 64;
				cursor = cl - 2;
				if (cursor >= c) cursor = 0;
				for (i = 0; i < cnt; i++) begin
					found = 0;
					if (free_left != 0) begin
						for (t = 0; t < c; t++) begin
							if (cursor >= c) cursor = 0;
							if (!is_used(cursor)) begin
								found = 1;
								break;
							end
							cursor++;
							if (cursor >= c) cursor = 0;
						end
					end
					if (!found) begin
						push_result(ST_NO_SPACE, 0, 0, 1);
						return;
					end
					used_map[cursor >> 5][cursor & 31] = 1'b1;
					free_left--;
					push_result(ST_OK, cursor + 2, 0, i + 1 == cnt);
				end
			end
			REQ_FREE: begin
				if (cnt > 64) cnt = 64;
				for (i = 0; i < cnt; i++) begin
					idx = cl + i - 2;
					if (idx >= c || !is_used(idx)) begin
						push_result(ST_ALREADY, cl + i, 0, 1);
						return;
					end
					used_map[idx >> 5][idx & 31] = 1'b0;
					if (free_left < c) free_left++;
				end
				push_result(ST_OK, 0, 0, 1);
			end
			REQ_FIND: begin
				s = cl - 2;
				run = 0;
				while (s < c && !is_used(s)) s++;
				if (s >= c) begin
					push_result(ST_OK, c, 0, 1);
				end else begin
					k = s;
					while (k < c && is_used(k)) begin
						run++;
						k++;
					end
					push_result(ST_OK, s + 2, run, 1);
				end
			end
			REQ_LOAD: begin
				used_map[wi] = wd;
				push_result(ST_OK, 0, 0, 1);
			end
			REQ_RECOUNT: begin
				n = 0;
				for (k = 0; k < c; k++)
					if (!is_used(k)) n++;
				free_left = n;
				push_result(ST_OK, 0, 0, 1);
			end
			default: ;
		endcase
	endfunction

	// entered and left at a falling edge, valid stays high on return
	task automatic send_req(logic [2:0] rt, logic [16:0] cl, logic [6:0] cnt,
		logic [10:0] wi, logic [31:0] wd);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.cluster <= cl;
		req_ch.count <= cnt;
		req_ch.word_index <= wi;
		req_ch.word_data <= wd;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_request(rt, cl, cnt, wi, wd);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_volume(logic [16:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		vol_reg = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom() | $urandom();
			default: return $urandom();
		endcase
	endfunction

	// words covering the largest random volume written once, scans stay inside them
	task automatic test_load_bitmap();
		set_volume(17'(LOADED * 32));
		for (int w = 0; w < LOADED; w++)
			send_req(REQ_LOAD, 17'($urandom()), 7'($urandom()), w[10:0], rand_word());
		send_req(REQ_RECOUNT, 0, 0, 0, 0);
	endtask

	task automatic test_directed();
		set_volume(17'd40);
		send_req(REQ_LOAD, 0, 0, 0, 32'h0);
		send_req(REQ_LOAD, 0, 0, 1, 32'h0);
		send_req(REQ_RECOUNT, 0, 0, 0, 0);
		// free count held at the volume size
		send_req(REQ_LOAD, 0, 0, 0, 32'hFFFF_FFFF);
		send_req(REQ_FREE, 17'd2, 7'd10, 0, 0);
		// hint out of range, then count above the burst with a stale free count
		send_req(REQ_ALLOC, 17'd1, 7'd3, 0, 0);
		send_req(REQ_ALLOC, 17'd65537, 7'd127, 0, 0);
		send_req(REQ_ALLOC, 17'd0, 7'd0, 0, 0);
		send_req(REQ_RECOUNT, 0, 0, 0, 0);
		send_req(REQ_ALLOC, 17'd2, 7'd1, 0, 0);
		send_req(REQ_FREE, 17'd0, 7'd1, 0, 0);
		send_req(REQ_FREE, 17'd65537, 7'd64, 0, 0);
		send_req(REQ_FREE, 17'd2, 7'd0, 0, 0);
		send_req(REQ_FREE, 17'd36, 7'd127, 0, 0);
		send_req(REQ_FIND, 17'd0, 0, 0, 0);
		send_req(REQ_FIND, 17'd65537, 0, 0, 0);
		send_req(REQ_FIND, 17'd2, 0, 0, 0);
		send_req(REQ_FIND, 17'd36, 0, 0, 0);
		send_req(3'd5, 17'd2, 7'd1, 0, 0);
		send_req(3'd6, 17'd2, 7'd1, 0, 0);
		send_req(3'd7, 17'd2, 7'd1, 0, 0);
		send_req(REQ_LOAD, 0, 0, 1, 32'h5555_AAAA);
		send_req(REQ_RECOUNT, 0, 0, 0, 0);
		send_req(REQ_ALLOC, 17'd41, 7'd64, 0, 0);
	endtask

	// register above the maximum, only the top bitmap word is touched
	task automatic test_volume_limit();
		set_volume(17'd131071);
		send_req(REQ_LOAD, 0, 0, 11'(NWORDS - 1), 32'h8000_0000);
		send_req(REQ_FREE, 17'd65537, 7'd2, 0, 0);
		send_req(REQ_ALLOC, 17'd65537, 7'd1, 0, 0);
		send_req(REQ_FIND, 17'd65537, 0, 0, 0);
		send_req(REQ_FIND, 17'd65538, 0, 0, 0);
		send_req(REQ_FREE, 17'd65537, 7'd1, 0, 0);
	endtask

	task automatic test_random_phase(logic [16:0] vol_val, int n);
		int unsigned c, r;
		logic [16:0] cl;
		logic [6:0] cnt;
		logic [10:0] wi;
		set_volume(vol_val);
		phases_run++;
		c = volume();
		send_req(REQ_RECOUNT, 0, 0, 0, 0);
		for (int j = 0; j < n; j++) begin
			cl = 17'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65537)
				: $urandom_range(2, c + 1));
			cnt = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
				: $urandom_range(1, 64));
			wi = 11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, NWORDS - 1)
				: $urandom_range(0, (c - 1) >> 5));
			if ($urandom_range(0, 39) == 0) drain();
			r = $urandom_range(0, 99);
			if (r < 35) send_req(REQ_ALLOC, cl, cnt, wi, $urandom());
			else if (r < 60) send_req(REQ_FREE, cl, cnt, wi, $urandom());
			else if (r < 75) send_req(REQ_FIND, cl, cnt, wi, $urandom());
			else if (r < 90) send_req(REQ_LOAD, cl, cnt, wi, rand_word());
			else if (r < 95) send_req(REQ_RECOUNT, cl, cnt, wi, $urandom());
			else send_req(3'($urandom_range(5, 7)), cl, cnt, wi, $urandom());
		end
	endtask

	task automatic test_random();
		test_random_phase(17'd0, 10);
		test_random_phase(17'd1, 10);
		test_random_phase(17'd64, 40);
		quiet = 1'b1;
		test_random_phase(17'd100, 30);
		quiet = 1'b0;
		for (int p = 0; p < 4; p++)
			test_random_phase(17'($urandom_range(2, 300)), 20);
		test_random_phase(17'd33, 28);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.cluster = '0;
		req_ch.count = '0;
		req_ch.word_index = '0;
		req_ch.word_data = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int w = 0; w < NWORDS; w++) used_map[w] = '0;
		cursor = 0;
		free_left = 0;
		vol_reg = 17'd65536;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		phases_run = 0;
		cycles = 0;
		quiet = 1'b0;
		took = 1'b0;
		res_stall = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_bitmap();
		test_directed();
		test_volume_limit();
		test_random();
		drain();

		$display("%0d requests sent, %0d results checked over %0d volume sizes",
			items_sent, results_seen, phases_run + 3);
		$display("covered allocate, free, find, load, recount and ignored request codes");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
